### rtl/sb_pkg.sv
package sb_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic        block_end;
    logic        message_end;
    logic [5:0]  tail_bytes;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        digest_last;
  } out_item_t;

  typedef logic [511:0] blk_t;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_KEY0,
    ST_ROUND_S,
    ST_ROUND_K,
    ST_FINISH,
    ST_ACCUM,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PASS_BLOCK,
    PASS_LEN,
    PASS_SUM
  } pass_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
    8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
    8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
    8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
    8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
    8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
    8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
    8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
    8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
    8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
    8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
    8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
    8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
    8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
    8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
  };

  localparam logic [63:0] MAT_A [64] = '{
    64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
    64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
    64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
    64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
    64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
    64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
    64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
    64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
    64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
    64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
    64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
    64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
    64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
    64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
    64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
    64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
  };

  localparam logic [511:0] RCON [12] = '{
    {64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
     64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
    {64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
     64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
    {64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
     64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
    {64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
     64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
    {64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
     64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
    {64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
     64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
    {64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
     64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
    {64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
     64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
    {64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
     64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
    {64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
     64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
    {64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
     64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
    {64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
     64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}
  };

  function automatic logic [63:0] lin64(input logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[63-i]) r = r ^ MAT_A[i];
    end
    return r;
  endfunction

endpackage

### rtl/sb_lps.sv
// One LPS pass over a 512-bit block: S-box, byte transpose, linear map.
module sb_lps (
  input  sb_pkg::blk_t din,
  output sb_pkg::blk_t dout
);
  always_comb begin
    logic [63:0] w;
    for (int i = 0; i < 8; i++) begin
      w = '0;
      for (int j = 0; j < 8; j++) begin
        w[63-8*j -: 8] = sb_pkg::SBOX[din[511-64*j-8*i -: 8]];
      end
      dout[511-64*i -: 64] = sb_pkg::lin64(w);
    end
  end
endmodule

### rtl/sb_add512.sv
// Adds two 512-bit numbers one 64-bit limb per cycle, least significant first.
module sb_add512 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [511:0] a,
  input  logic [511:0] b,
  output logic [511:0] sum,
  output logic        done
);
  logic [2:0]  limb;
  logic        busy;
  logic        carry;
  logic [64:0] part;

  assign part = {1'b0, a[64*limb +: 64]} + {1'b0, b[64*limb +: 64]} + {64'd0, carry};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      limb <= '0;
      carry <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        limb <= '0;
        carry <= 1'b0;
      end else if (busy) begin
        sum[64*limb +: 64] <= part[63:0];
        carry <= part[64];
        limb <= limb + 3'd1;
        if (limb == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/streebog_hash.sv
// A word that does not complete a block is taken while in_ready stays high. A completing
// word holds in_ready low through the compression (25 LPS passes through one shared LPS
// unit plus the chain update) and then the limb-serial N and Sigma adds.
// A final block holds it through two more compressions, then 4 or 8 digest words leave
// one per accepted cycle before the next request is taken.
// Reset (synchronous, rst high) selects 512-bit mode and starts an empty message.
module streebog_hash #(
  parameter int ROUNDS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sb_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sb_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_data
);
  localparam int RW = $clog2(ROUNDS + 1);

  sb_pkg::state_t st, st_next;
  sb_pkg::pass_t  pass;
  logic           mode;
  logic [63:0]    buf_mem [8];
  logic [2:0]     word_position;
  logic [511:0]   chain_value, length_counter, checksum_sum;
  logic [511:0]   key, rstate, msg, ctr_sel;
  logic [RW-1:0]  rnd;
  logic           is_final;
  logic [5:0]     tail;
  logic [2:0]     emit_idx;
  logic           acc_step;   // 0: length add, 1: checksum add
  logic [511:0]   lps_in, lps_out;
  logic [511:0]   add_a, add_b, add_sum;
  logic           add_start, add_done;
  logic           add_restart;
  logic [511:0]   padded;
  logic [511:0]   blk;

  sb_lps u_lps (.din(lps_in), .dout(lps_out));
  sb_add512 u_add (.clk(clk), .rst(rst), .start(add_start), .a(add_a), .b(add_b),
                   .sum(add_sum), .done(add_done));

  logic accept_in;
  assign in_ready  = (st == sb_pkg::ST_COLLECT);
  assign accept_in = in_valid && in_ready;

  always_comb begin
    for (int k = 0; k < 8; k++) blk[511-64*k -: 64] = buf_mem[k];
    if (accept_in) blk[511-64*word_position -: 64] = in_data.data_word;
  end

  // Padding: bytes ahead of the tail cleared, a 0x01 marker just before it.
  always_comb begin
    logic [6:0] pad_at;
    pad_at = 7'd63 - {1'b0, in_data.tail_bytes};
    for (int b = 0; b < 64; b++) begin
      if (b < pad_at) padded[511-8*b -: 8] = 8'h00;
      else if (b == pad_at) padded[511-8*b -: 8] = 8'h01;
      else padded[511-8*b -: 8] = blk[511-8*b -: 8];
    end
  end

  always_comb begin
    case (pass)
      sb_pkg::PASS_BLOCK: ctr_sel = length_counter;
      default:            ctr_sel = '0;
    endcase
  end

  always_comb begin
    case (st)
      sb_pkg::ST_KEY0:    lps_in = chain_value ^ ctr_sel;
      sb_pkg::ST_ROUND_S: lps_in = rstate;
      default:            lps_in = key ^ sb_pkg::RCON[rnd[3:0]];
    endcase
  end

  always_comb begin
    add_a = length_counter;
    add_b = '0;
    if (!acc_step) begin
      add_b[15:0] = is_final ? {7'd0, tail, 3'd0} : 16'd512;
    end else begin
      add_a = checksum_sum;
      add_b = msg;
    end
  end

  // The second add starts when the first completes.
  assign add_restart = (st == sb_pkg::ST_ACCUM) && add_done && !acc_step;
  assign add_start = ((st == sb_pkg::ST_FINISH) && (pass == sb_pkg::PASS_BLOCK)) ||
                     add_restart;

  always_comb begin
    st_next = st;
    case (st)
      sb_pkg::ST_COLLECT:
        if (accept_in && (in_data.block_end || word_position == 3'd7)) st_next = sb_pkg::ST_KEY0;
      sb_pkg::ST_KEY0:    st_next = sb_pkg::ST_ROUND_S;
      sb_pkg::ST_ROUND_S: st_next = sb_pkg::ST_ROUND_K;
      sb_pkg::ST_ROUND_K:
        st_next = (rnd == RW'(ROUNDS - 1)) ? sb_pkg::ST_FINISH : sb_pkg::ST_ROUND_S;
      sb_pkg::ST_FINISH:
        if (pass == sb_pkg::PASS_BLOCK) st_next = sb_pkg::ST_ACCUM;
        else if (pass == sb_pkg::PASS_LEN) st_next = sb_pkg::ST_KEY0;
        else st_next = sb_pkg::ST_EMIT;
      sb_pkg::ST_ACCUM:
        if (add_done && acc_step)
          st_next = is_final ? sb_pkg::ST_KEY0 : sb_pkg::ST_COLLECT;
      sb_pkg::ST_EMIT:
        if (out_ready && emit_idx == (mode ? 3'd3 : 3'd7)) st_next = sb_pkg::ST_COLLECT;
      default: st_next = sb_pkg::ST_COLLECT;
    endcase
  end

  assign out_valid = (st == sb_pkg::ST_EMIT);
  always_comb begin
    out_data.digest_word = chain_value[511-64*emit_idx -: 64];
    out_data.digest_last = (emit_idx == (mode ? 3'd3 : 3'd7));
  end

  always_ff @(posedge clk) begin
    if (accept_in) buf_mem[word_position] <= in_data.data_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= sb_pkg::ST_COLLECT;
      mode <= 1'b0;
      word_position <= '0;
      chain_value <= '0;
      length_counter <= '0;
      checksum_sum <= '0;
      pass <= sb_pkg::PASS_BLOCK;
      emit_idx <= '0;
      acc_step <= 1'b0;
      rnd <= '0;
      is_final <= 1'b0;
    end else if (cfg_we) begin
      mode <= cfg_data;
      chain_value <= {64{{7'd0, cfg_data}}};
      length_counter <= '0;
      checksum_sum <= '0;
      word_position <= '0;
      st <= sb_pkg::ST_COLLECT;
    end else begin
      st <= st_next;
      case (st)
        sb_pkg::ST_COLLECT: if (accept_in) begin
          if (st_next == sb_pkg::ST_KEY0) begin
            word_position <= '0;
            is_final <= in_data.message_end;
            tail <= in_data.tail_bytes;
            msg <= in_data.message_end ? padded : blk;
            pass <= sb_pkg::PASS_BLOCK;
          end else begin
            word_position <= word_position + 3'd1;
          end
        end
        sb_pkg::ST_KEY0: begin
          key <= lps_out;
          rstate <= lps_out ^ msg;
          rnd <= '0;
        end
        sb_pkg::ST_ROUND_S: rstate <= lps_out;
        sb_pkg::ST_ROUND_K: begin
          key <= lps_out;
          rstate <= rstate ^ lps_out;
          rnd <= rnd + RW'(1);
        end
        sb_pkg::ST_FINISH: begin
          chain_value <= chain_value ^ rstate ^ msg;
          acc_step <= 1'b0;
          if (pass == sb_pkg::PASS_LEN) begin
            pass <= sb_pkg::PASS_SUM;
            msg <= checksum_sum;
          end
          emit_idx <= '0;
        end
        sb_pkg::ST_ACCUM: if (add_done) begin
          if (!acc_step) begin
            length_counter <= add_sum;
            acc_step <= 1'b1;
          end else begin
            checksum_sum <= add_sum;
            pass <= sb_pkg::PASS_LEN;
            msg <= length_counter;
          end
        end
        sb_pkg::ST_EMIT: if (out_ready) begin
          emit_idx <= emit_idx + 3'd1;
          if (st_next == sb_pkg::ST_COLLECT) begin
            chain_value <= {64{{7'd0, mode}}};
            length_counter <= '0;
            checksum_sum <= '0;
            word_position <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
